// ===== hdl/cpuw_pkg.sv =====
// shared types, constants and tables for the complex phase unwrapper
`timescale 1ns / 1ps
`default_nettype none
package cpuw_pkg;

  // sample and phase sizes
  localparam int SAMPLE_BITS   = 16;
  localparam int PHASE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int COUNT_BITS    = 16;
  localparam int RESULT_BITS   = 32;

  // cordic datapath: samples scaled to a 40 bit magnitude, 3 bits of growth
  localparam int SCALE_SHIFT = 40 - SAMPLE_BITS;
  localparam int XY_BITS     = 43;
  // angle datapath: pi = 2^30
  localparam int ANGLE_BITS  = 33;

  localparam logic signed [ANGLE_BITS-1:0] ANGLE_HALF_PI = ANGLE_BITS'(64'sd536870912);
  localparam logic signed [ANGLE_BITS-1:0] ROUND_BIAS    =
    ANGLE_BITS'(64'sd1 <<< (30 - PHASE_BITS));

  // atan(2^-i), pi = 2^30
  localparam int ATAN_TABLE [24] = '{
    268435456, 158466703, 83729454, 42502378, 21333666,
    10677233, 5339919, 2670123, 1335082, 667543, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41
  };

  // unwrap limits
  localparam logic signed [PHASE_BITS:0] JUMP_MAX =
    (PHASE_BITS+1)'(64'sd1 <<< (PHASE_BITS - 1));
  localparam logic signed [PHASE_BITS:0] JUMP_MIN = -JUMP_MAX;
  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(32767);
  localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = -COUNT_MAX;

  // queue between cordic front and unwrap back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [PHASE_BITS-1:0] phase;
    logic                         last;
  } cpuw_item_t;

endpackage
`default_nettype wire

// ===== hdl/cpuw_cordic.sv =====
// front end: pipelined vectoring cordic that turns a sample into a wrapped phase
`timescale 1ns / 1ps
`default_nettype none
module cpuw_cordic import cpuw_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_i,
  input  wire logic signed [SAMPLE_BITS-1:0] in_q,
  input  wire logic                          in_last,
  output logic                               out_valid,
  output cpuw_item_t                         out_item,
  input  wire logic                          out_full
);

  logic [CORDIC_STAGES:0] valid;
  logic                   advance;

  logic signed [XY_BITS-1:0]    x    [CORDIC_STAGES+1];
  logic signed [XY_BITS-1:0]    y    [CORDIC_STAGES+1];
  logic signed [ANGLE_BITS-1:0] z    [CORDIC_STAGES+1];
  logic                         zero [CORDIC_STAGES+1];
  logic                         last [CORDIC_STAGES+1];

  logic signed [XY_BITS-1:0]    xs;
  logic signed [XY_BITS-1:0]    ys;
  logic signed [ANGLE_BITS-1:0] zsum;

  // whole pipeline stalls only when the last stage cannot drain
  assign advance  = !(valid[CORDIC_STAGES] && out_full);
  assign in_ready = advance;

  // valid bits shift along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[CORDIC_STAGES-1:0], in_valid};
    end
  end

  // scale samples and pre-rotate the left half plane by +-pi/2
  assign xs = XY_BITS'(in_i) <<< SCALE_SHIFT;
  assign ys = XY_BITS'(in_q) <<< SCALE_SHIFT;

  always_ff @(posedge clk) begin
    if (advance) begin
      zero[0] <= (in_i == '0) && (in_q == '0);
      last[0] <= in_last;
      if (xs < 0) begin
        if (ys >= 0) begin
          x[0] <= ys;
          y[0] <= -xs;
          z[0] <= ANGLE_HALF_PI;
        end else begin
          x[0] <= -ys;
          y[0] <= xs;
          z[0] <= -ANGLE_HALF_PI;
        end
      end else begin
        x[0] <= xs;
        y[0] <= ys;
        z[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage, driving y toward zero
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (advance) begin
        zero[k+1] <= zero[k];
        last[k+1] <= last[k];
        if (y[k] >= 0) begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + ANGLE_BITS'(ATAN_TABLE[k]);
        end else begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - ANGLE_BITS'(ATAN_TABLE[k]);
        end
      end
    end
  end

  // round to the phase grid, +pi folds onto -pi by truncation
  assign zsum = z[CORDIC_STAGES] + ROUND_BIAS;

  always_comb begin
    out_item.last  = last[CORDIC_STAGES];
    out_item.phase = zero[CORDIC_STAGES] ? '0 : zsum[30 -: PHASE_BITS];
  end

  assign out_valid = valid[CORDIC_STAGES] && !out_full;

  // a stalled last stage keeps its beat
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (valid[CORDIC_STAGES] && out_full) |=> valid[CORDIC_STAGES])
    else $error("cordic dropped a stalled beat");

  // nothing is taken in while the pipeline is frozen
  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(valid))
    else $error("cordic valid bits moved during a stall");

endmodule
`default_nettype wire

// ===== hdl/cpuw_fifo.sv =====
// short queue of wrapped phases between the cordic and the unwrap stage
`timescale 1ns / 1ps
`default_nettype none
module cpuw_fifo import cpuw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  cpuw_item_t      wr_item,
  output logic            full,
  input  wire logic       rd_en,
  output cpuw_item_t      rd_item,
  output logic            rd_valid
);

  cpuw_item_t             slot [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_wr;
  logic                   do_rd;

  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slot[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full))
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && !rd_valid))
    else $error("read from an empty queue");

endmodule
`default_nettype wire

// ===== hdl/cpuw_unwrap.sv =====
// back end: wrap counting and output register
`timescale 1ns / 1ps
`default_nettype none
module cpuw_unwrap import cpuw_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  cpuw_item_t                  q_item,
  output logic                        q_take,
  output logic                        out_valid,
  output logic signed [RESULT_BITS-1:0] out_phase,
  output logic                        out_last,
  input  wire logic                   out_pop
);

  logic signed [PHASE_BITS-1:0]  previous_phase;
  logic signed [COUNT_BITS-1:0]  wrap_count;
  logic                          first_of_list;

  logic signed [PHASE_BITS:0]    jump;
  logic signed [COUNT_BITS-1:0]  wrap_count_next;
  logic signed [RESULT_BITS-1:0] total;

  // take a beat whenever the output register is free or being emptied
  assign q_take = q_valid && (!out_valid || out_pop);

  // step between wrapped phases and saturating wrap count
  assign jump = (PHASE_BITS+1)'(q_item.phase) - (PHASE_BITS+1)'(previous_phase);

  always_comb begin
    wrap_count_next = wrap_count;
    if (!first_of_list) begin
      priority if (jump > JUMP_MAX && wrap_count > COUNT_MIN) begin
        wrap_count_next = wrap_count - 1'b1;
      end else if (jump < JUMP_MIN && wrap_count < COUNT_MAX) begin
        wrap_count_next = wrap_count + 1'b1;
      end else begin
        wrap_count_next = wrap_count;
      end
    end
  end

  assign total = (RESULT_BITS'(wrap_count_next) <<< PHASE_BITS) + RESULT_BITS'(q_item.phase);

  // history, cleared at the end of a list
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_phase <= '0;
      wrap_count     <= '0;
      first_of_list  <= 1'b1;
    end else if (q_take) begin
      if (q_item.last) begin
        previous_phase <= '0;
        wrap_count     <= '0;
        first_of_list  <= 1'b1;
      end else begin
        previous_phase <= q_item.phase;
        wrap_count     <= wrap_count_next;
        first_of_list  <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_phase <= total;
      out_last  <= q_item.last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    wrap_count >= COUNT_MIN && wrap_count <= COUNT_MAX)
    else $error("wrap count outside its limits");

  a_list_end_clears: assert property (@(posedge clk) disable iff (rst)
    (q_take && q_item.last) |=> (first_of_list && wrap_count == '0))
    else $error("history not cleared after the last beat of a list");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_pop) |=> (out_valid && $stable(out_phase)))
    else $error("waiting result changed");

endmodule
`default_nettype wire

// ===== hdl/complex_phase_unwrap.sv =====
// top level of the complex phase unwrapper
//
// Input channel: sample_i, sample_q, last_in are taken as one beat at a
// rising edge with push high and full low. Output channel: unwrapped_phase
// and last_out hold the oldest result while empty is low; pop high at such
// an edge takes it. One result comes out for every beat taken in, in order.
// Each sample goes through a vectoring cordic (one pre-rotation register
// and 16 micro-rotation stages), a two entry queue and then the unwrap
// stage, which registers the result. Sustained throughput is one beat per
// cycle while pop keeps up. When the receiver stops popping, the output
// register and the queue fill, the cordic pipeline freezes as a whole and
// full rises; nothing is lost. The phase is scaled so that pi is 32768;
// the result moves by 65536 per turn of the wrap count, which saturates at
// +-32767 turns. A beat with last_in set ends a list: history and wrap
// count are cleared after its result.
// Reset (rst, synchronous) empties pipeline, queue and output register and
// clears the history; full and empty are valid in the first cycle after.
`timescale 1ns / 1ps
`default_nettype none
module complex_phase_unwrap import cpuw_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_q,
  input  wire logic                          last_in,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [RESULT_BITS-1:0]      unwrapped_phase,
  output logic                               last_out
);

  logic       front_ready;
  logic       front_valid;
  cpuw_item_t front_item;
  logic       q_full;
  logic       q_valid;
  cpuw_item_t q_item;
  logic       q_take;
  logic       out_valid;

  // front: angle of each sample
  cpuw_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (front_ready),
    .in_i      (sample_i),
    .in_q      (sample_q),
    .in_last   (last_in),
    .out_valid (front_valid),
    .out_item  (front_item),
    .out_full  (q_full)
  );

  // queue between front and back
  cpuw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid),
    .wr_item  (front_item),
    .full     (q_full),
    .rd_en    (q_take),
    .rd_item  (q_item),
    .rd_valid (q_valid)
  );

  // back: unwrap and hold the result
  cpuw_unwrap u_unwrap (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_phase (unwrapped_phase),
    .out_last  (last_out),
    .out_pop   (pop)
  );

  assign full  = !front_ready;
  assign empty = !out_valid;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not empty after reset");

endmodule
`default_nettype wire
